### rtl/prc_pkg.sv
// ----------------------------------------------------------------------------
// prc_pkg: shared types and constants for the point rotation block
// Widths of the coordinate, phase and gain datapaths, the arctangent table
// and the payload records that travel between the pipeline parts.
// ----------------------------------------------------------------------------
package prc_pkg;

  // Coordinate and rotation configuration
  localparam int COORD_W         = 24;   // signed, 8 fraction bits
  localparam int ROTATION_STAGES = 16;   // micro-rotations in the cell row
  localparam int ANGLE_W         = 17;   // degrees, 7 fraction bits
  localparam int GUARD_BITS      = 16;   // extra fraction bits in the vector

  // Degree to binary-angle conversion: full turn of 46080 = 1024 * 45
  localparam int DEG_FRACTION  = 128;
  localparam int HALF_TURN_DEG = 180;
  localparam int FULL_TURN     = 2 * HALF_TURN_DEG * DEG_FRACTION;
  localparam int PHASE_W       = 32;
  localparam int PRE_SHIFT     = 10;                        // power-of-two part
  localparam int PHASE_DIV     = FULL_TURN >> PRE_SHIFT;    // odd part, 45
  localparam int SCALE_SHIFT   = PHASE_W - PRE_SHIFT;       // 22
  localparam longint PHASE_QUOT = (64'sd1 <<< SCALE_SHIFT) / PHASE_DIV;
  localparam longint PHASE_REM  = (64'sd1 <<< SCALE_SHIFT) % PHASE_DIV;
  localparam longint PHASE_RND  = (FULL_TURN / 2) >> PRE_SHIFT;
  localparam int MAG_W         = ANGLE_W;                   // |angle| fits
  localparam int QUOT_PROD_W   = 2 * MAG_W;
  localparam int REM_W         = MAG_W + 6;                 // |angle|*rem + rnd
  localparam int RECIP_SHIFT   = REM_W + 6;                 // exact for REM_W bits
  localparam longint RECIP     = ((64'sd1 <<< RECIP_SHIFT) + PHASE_DIV - 1) / PHASE_DIV;
  localparam int RECIP_W       = REM_W;
  localparam int RECIP_PROD_W  = REM_W + RECIP_W;
  localparam int FRAC_Q_W      = RECIP_PROD_W - RECIP_SHIFT;

  // Vector and residual angle widths
  localparam int DIFF_W = COORD_W + 1;
  localparam int VEC_W  = COORD_W + GUARD_BITS + 4;
  localparam int Z_W    = PHASE_W;
  localparam int IDX_W  = 5;

  // Gain compensation: 0.60725293500888 as unsigned Q0.32
  localparam int     GAIN_W     = 32;
  localparam longint GAIN_Q32   = 64'd2608131496;
  localparam int     SPLIT      = 26;
  localparam int     HI_W       = VEC_W - SPLIT;
  localparam int     A_W        = HI_W + GAIN_W;
  localparam int     B_W        = SPLIT + GAIN_W;
  localparam int     LOW_SUM_W  = B_W + 1;
  localparam int     SUM_W      = A_W - (GAIN_W - SPLIT) + 1;
  localparam int     RND_W      = SUM_W + 1 - GUARD_BITS;
  localparam int     RES_W      = ((RND_W > COORD_W) ? RND_W : COORD_W) + 2;

  // Result range
  localparam longint COORD_MAX = (64'sd1 <<< (COORD_W - 1)) - 1;
  localparam longint COORD_MIN = -COORD_MAX - 1;

  // Record handed from cell to cell
  typedef struct packed {
    logic signed [VEC_W-1:0]   x;
    logic signed [VEC_W-1:0]   y;
    logic signed [Z_W-1:0]     z;
    logic signed [COORD_W-1:0] cx;
    logic signed [COORD_W-1:0] cy;
  } rot_t;

  // Finished result
  typedef struct packed {
    logic signed [COORD_W-1:0] rx;
    logic signed [COORD_W-1:0] ry;
    logic                      sat;
  } res_t;

  // Arctangent of 2^-i as a binary angle, 2^32 per full turn
  function automatic logic [PHASE_W-1:0] atan_phase(input logic [IDX_W-1:0] idx);
    logic [PHASE_W-1:0] val;
    case (idx)
      5'd0:    val = 32'h20000000;
      5'd1:    val = 32'h12E4051D;
      5'd2:    val = 32'h09FB385B;
      5'd3:    val = 32'h051111D4;
      5'd4:    val = 32'h028B0D43;
      5'd5:    val = 32'h0145D7E1;
      5'd6:    val = 32'h00A2F61E;
      5'd7:    val = 32'h00517C55;
      5'd8:    val = 32'h0028BE53;
      5'd9:    val = 32'h00145F2E;
      5'd10:   val = 32'h000A2F98;
      5'd11:   val = 32'h000517CC;
      5'd12:   val = 32'h00028BE6;
      5'd13:   val = 32'h000145F3;
      5'd14:   val = 32'h0000A2F9;
      5'd15:   val = 32'h0000517C;
      5'd16:   val = 32'h000028BE;
      5'd17:   val = 32'h0000145F;
      5'd18:   val = 32'h00000A2F;
      5'd19:   val = 32'h00000517;
      5'd20:   val = 32'h0000028B;
      5'd21:   val = 32'h00000145;
      5'd22:   val = 32'h000000A2;
      5'd23:   val = 32'h00000051;
      5'd24:   val = 32'h00000028;
      5'd25:   val = 32'h00000014;
      5'd26:   val = 32'h0000000A;
      5'd27:   val = 32'h00000005;
      5'd28:   val = 32'h00000002;
      5'd29:   val = 32'h00000001;
      default: val = 32'h00000000;
    endcase
    return val;
  endfunction

endpackage

### rtl/prc_in_if.sv
// ----------------------------------------------------------------------------
// prc_in_if: point request channel
// Valid/ready channel carrying a center point, an end point and an angle.
// ----------------------------------------------------------------------------
interface prc_in_if;
  logic                               valid;
  logic                               ready;
  logic signed [prc_pkg::COORD_W-1:0] center_x;
  logic signed [prc_pkg::COORD_W-1:0] center_y;
  logic signed [prc_pkg::COORD_W-1:0] end_x;
  logic signed [prc_pkg::COORD_W-1:0] end_y;
  logic signed [prc_pkg::ANGLE_W-1:0] angle_deg;

  modport source (output valid, center_x, center_y, end_x, end_y, angle_deg,
                  input ready);
  modport sink   (input valid, center_x, center_y, end_x, end_y, angle_deg,
                  output ready);
endinterface

### rtl/prc_out_if.sv
// ----------------------------------------------------------------------------
// prc_out_if: rotated point channel
// Valid/ready channel carrying the rotated point and its clip flag.
// ----------------------------------------------------------------------------
interface prc_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [prc_pkg::COORD_W-1:0] rotated_x;
  logic signed [prc_pkg::COORD_W-1:0] rotated_y;
  logic                               saturated;

  modport source (output valid, rotated_x, rotated_y, saturated, input ready);
  modport sink   (input valid, rotated_x, rotated_y, saturated, output ready);
endinterface

### rtl/point_rotate_about_center_top.sv
// ----------------------------------------------------------------------------
// point_rotate_about_center_top: rotate a point about a center (CORDIC)
// Takes a center, an end point and an angle in degrees on point_in and
// returns the end point rotated counter-clockwise about the center on
// point_out, saturated to the coordinate range with a clip flag.
// Both channels are valid/ready; a request moves when valid and ready are
// both high. One result leaves for every request, in request order.
// The stages, in order, are angle to binary-angle conversion, quadrant
// fold, one cell per micro-rotation, then magnitude, gain products,
// rounding and recentering with clipping. Throughput is one request per
// cycle while the receiver is ready; every stage is a register with
// its own valid, so a bubble anywhere in the row is filled while a
// finished result waits at the output. When the receiver stalls, results
// back up stage by stage and point_in.ready drops only once the whole row
// is full. Coincident points return the center with no clip.
// Synchronous reset empties every stage; no result is pending after it.
// ----------------------------------------------------------------------------
module point_rotate_about_center_top (
  input logic      clk,
  input logic      rst,
  prc_in_if.sink   point_in,
  prc_out_if.source point_out
);

  localparam int N = prc_pkg::ROTATION_STAGES;

  // Conversion stage registers
  logic                                   cvt_valid;
  logic                                   cvt_ready;
  logic                                   cvt_neg;
  logic [prc_pkg::PHASE_W-1:0]            cvt_whole;
  logic [prc_pkg::FRAC_Q_W-1:0]           cvt_frac;
  logic signed [prc_pkg::DIFF_W-1:0]      cvt_dx;
  logic signed [prc_pkg::DIFF_W-1:0]      cvt_dy;
  logic signed [prc_pkg::COORD_W-1:0]     cvt_cx;
  logic signed [prc_pkg::COORD_W-1:0]     cvt_cy;

  // Conversion next values
  logic                                   ang_neg;
  logic [prc_pkg::MAG_W-1:0]              ang_mag;
  logic [prc_pkg::QUOT_PROD_W-1:0]        whole_prod;
  logic [prc_pkg::REM_W-1:0]              rem_val;
  logic [prc_pkg::RECIP_PROD_W-1:0]       recip_prod;

  // Fold stage values
  logic [prc_pkg::PHASE_W-1:0]            phase_raw;
  logic [prc_pkg::PHASE_W-1:0]            phase_sgn;
  logic                                   fold;
  logic signed [prc_pkg::VEC_W-1:0]       x_ext;
  logic signed [prc_pkg::VEC_W-1:0]       y_ext;
  prc_pkg::rot_t                          fold_next;
  logic                                   fold_ready;

  // Cell row; row_ready[k] is the ready of the stage that takes row_data[k]
  logic                                   row_valid [N+1];
  logic                                   row_ready [N+1];
  prc_pkg::rot_t                          row_data  [N+1];

  prc_pkg::res_t                          res_data;

  // Accept a request when the conversion stage can move
  assign cvt_ready      = ~cvt_valid | fold_ready;
  assign point_in.ready = cvt_ready;

  // Degrees to binary angle: |a| * 2^22 / 45 split into whole and fraction
  always_comb begin
    ang_neg    = point_in.angle_deg[prc_pkg::ANGLE_W-1];
    ang_mag    = ang_neg ? prc_pkg::MAG_W'(-point_in.angle_deg)
                         : prc_pkg::MAG_W'(point_in.angle_deg);
    whole_prod = prc_pkg::QUOT_PROD_W'(ang_mag)
               * prc_pkg::QUOT_PROD_W'(prc_pkg::PHASE_QUOT);
    rem_val    = prc_pkg::REM_W'(ang_mag) * prc_pkg::REM_W'(prc_pkg::PHASE_REM)
               + prc_pkg::REM_W'(prc_pkg::PHASE_RND);
    recip_prod = prc_pkg::RECIP_PROD_W'(rem_val)
               * prc_pkg::RECIP_PROD_W'(prc_pkg::RECIP);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cvt_valid <= 1'b0;
    end else if (cvt_ready) begin
      cvt_valid <= point_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cvt_ready && point_in.valid) begin
      cvt_neg   <= ang_neg;
      cvt_whole <= whole_prod[prc_pkg::PHASE_W-1:0];
      cvt_frac  <= recip_prod[prc_pkg::RECIP_PROD_W-1:prc_pkg::RECIP_SHIFT];
      cvt_dx    <= prc_pkg::DIFF_W'(point_in.end_x) - prc_pkg::DIFF_W'(point_in.center_x);
      cvt_dy    <= prc_pkg::DIFF_W'(point_in.end_y) - prc_pkg::DIFF_W'(point_in.center_y);
      cvt_cx    <= point_in.center_x;
      cvt_cy    <= point_in.center_y;
    end
  end

  // Sign the phase; fold the second and third quadrants by a half turn
  always_comb begin
    phase_raw = cvt_whole + prc_pkg::PHASE_W'(cvt_frac);
    phase_sgn = cvt_neg ? -phase_raw : phase_raw;
    fold      = phase_sgn[prc_pkg::PHASE_W-1] ^ phase_sgn[prc_pkg::PHASE_W-2];
    x_ext     = prc_pkg::VEC_W'(cvt_dx) <<< prc_pkg::GUARD_BITS;
    y_ext     = prc_pkg::VEC_W'(cvt_dy) <<< prc_pkg::GUARD_BITS;
    fold_next.x  = fold ? -x_ext : x_ext;
    fold_next.y  = fold ? -y_ext : y_ext;
    fold_next.z  = {phase_sgn[prc_pkg::PHASE_W-1] ^ fold,
                    phase_sgn[prc_pkg::PHASE_W-2:0]};
    fold_next.cx = cvt_cx;
    fold_next.cy = cvt_cy;
  end

  // Fold register moves when empty or when the first cell takes its request
  assign fold_ready = ~row_valid[0] | row_ready[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid[0] <= 1'b0;
    end else if (fold_ready) begin
      row_valid[0] <= cvt_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fold_ready && cvt_valid) begin
      row_data[0] <= fold_next;
    end
  end

  // Row of micro-rotation cells
  for (genvar k = 0; k < N; k++) begin : g_cell
    prc_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .stage_idx (prc_pkg::IDX_W'(k)),
      .in_valid  (row_valid[k]),
      .in_ready  (row_ready[k]),
      .in_data   (row_data[k]),
      .out_valid (row_valid[k+1]),
      .out_ready (row_ready[k+1]),
      .out_data  (row_data[k+1])
    );
  end

  // Gain compensation, recentering and clipping
  prc_gain u_gain (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (row_valid[N]),
    .in_ready  (row_ready[N]),
    .in_data   (row_data[N]),
    .out_valid (point_out.valid),
    .out_ready (point_out.ready),
    .out_data  (res_data)
  );

  assign point_out.rotated_x = res_data.rx;
  assign point_out.rotated_y = res_data.ry;
  assign point_out.saturated = res_data.sat;

endmodule

### rtl/prc_cell.sv
// ----------------------------------------------------------------------------
// prc_cell: one CORDIC micro-rotation
// Rotates the vector by +-atan(2^-i) toward a zero residual angle, with i
// set by the cell's place in the row, and registers the record for the
// next cell.
// ----------------------------------------------------------------------------
module prc_cell (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [prc_pkg::IDX_W-1:0]      stage_idx,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  prc_pkg::rot_t                  in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output prc_pkg::rot_t                  out_data
);

  prc_pkg::rot_t                         data_next;
  logic signed [prc_pkg::VEC_W-1:0]      x_cur;
  logic signed [prc_pkg::VEC_W-1:0]      y_cur;
  logic signed [prc_pkg::VEC_W-1:0]      x_sh;
  logic signed [prc_pkg::VEC_W-1:0]      y_sh;
  logic signed [prc_pkg::Z_W-1:0]        z_cur;
  logic signed [prc_pkg::Z_W-1:0]        z_step;

  // Take a new request whenever this stage is empty or drains
  assign in_ready = ~out_valid | out_ready;

  // Micro-rotation: floor shifts, direction from the residual sign
  always_comb begin
    x_cur  = in_data.x;
    y_cur  = in_data.y;
    z_cur  = in_data.z;
    x_sh   = x_cur >>> stage_idx;
    y_sh   = y_cur >>> stage_idx;
    z_step = prc_pkg::Z_W'(prc_pkg::atan_phase(stage_idx));
    data_next    = in_data;
    if (!z_cur[prc_pkg::Z_W-1]) begin
      data_next.x = x_cur - y_sh;
      data_next.y = y_cur + x_sh;
      data_next.z = z_cur - z_step;
    end else begin
      data_next.x = x_cur + y_sh;
      data_next.y = y_cur - x_sh;
      data_next.z = z_cur + z_step;
    end
  end

  // Hold valid until the neighbor takes the request
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  // Advance the payload
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= data_next;
    end
  end

endmodule

### rtl/prc_gain.sv
// ----------------------------------------------------------------------------
// prc_gain: CORDIC gain compensation, recentering and clipping
// Four stages per coordinate lane: magnitude, split gain products,
// truncate and round off the guard bits, add the center and saturate.
// ----------------------------------------------------------------------------
module prc_gain (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  prc_pkg::rot_t in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output prc_pkg::res_t out_data
);

  localparam int LANES = 2;

  // Stage valids and readies
  logic [3:0] vld;
  logic [3:0] rdy;

  // Magnitude stage
  logic                               neg0 [LANES];
  logic [prc_pkg::VEC_W-1:0]          mag0 [LANES];
  logic signed [prc_pkg::COORD_W-1:0] ctr0 [LANES];
  // Product stage
  logic                               neg1 [LANES];
  logic [prc_pkg::A_W-1:0]            prod_a1 [LANES];
  logic [prc_pkg::B_W-1:0]            prod_b1 [LANES];
  logic signed [prc_pkg::COORD_W-1:0] ctr1 [LANES];
  // Rounding stage
  logic                               neg2 [LANES];
  logic [prc_pkg::RND_W-1:0]          rnd2 [LANES];
  logic signed [prc_pkg::COORD_W-1:0] ctr2 [LANES];

  // Combinational next values
  logic signed [prc_pkg::VEC_W-1:0]   vec_in [LANES];
  logic [prc_pkg::VEC_W-1:0]          mag_next [LANES];
  logic [prc_pkg::A_W-1:0]            prod_a_next [LANES];
  logic [prc_pkg::B_W-1:0]            prod_b_next [LANES];
  logic [prc_pkg::LOW_SUM_W-1:0]      low_sum [LANES];
  logic [prc_pkg::SUM_W-1:0]          sum_full [LANES];
  logic [prc_pkg::SUM_W:0]            sum_rnd [LANES];
  logic [prc_pkg::RND_W-1:0]          rnd_next [LANES];
  logic signed [prc_pkg::RES_W-1:0]   res_full [LANES];
  logic signed [prc_pkg::RES_W-1:0]   off_val [LANES];
  logic signed [prc_pkg::RES_W-1:0]   lim_hi;
  logic signed [prc_pkg::RES_W-1:0]   lim_lo;
  logic signed [prc_pkg::COORD_W-1:0] res_next [LANES];
  logic                               clip [LANES];

  // Ready chain: a stage moves when empty or when its successor moves
  always_comb begin
    rdy[3] = ~vld[3] | out_ready;
    rdy[2] = ~vld[2] | rdy[3];
    rdy[1] = ~vld[1] | rdy[2];
    rdy[0] = ~vld[0] | rdy[1];
  end
  assign in_ready  = rdy[0];
  assign out_valid = vld[3];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) vld[0] <= in_valid;
      if (rdy[1]) vld[1] <= vld[0];
      if (rdy[2]) vld[2] <= vld[1];
      if (rdy[3]) vld[3] <= vld[2];
    end
  end

  // Per-lane datapath: lane 0 is x, lane 1 is y
  assign lim_hi = prc_pkg::RES_W'(prc_pkg::COORD_MAX);
  assign lim_lo = prc_pkg::RES_W'(prc_pkg::COORD_MIN);

  always_comb begin
    vec_in[0] = in_data.x;
    vec_in[1] = in_data.y;
    for (int l = 0; l < LANES; l++) begin
      mag_next[l] = vec_in[l][prc_pkg::VEC_W-1] ? prc_pkg::VEC_W'(-vec_in[l])
                                                : prc_pkg::VEC_W'(vec_in[l]);
      prod_a_next[l] = prc_pkg::A_W'(mag0[l][prc_pkg::VEC_W-1:prc_pkg::SPLIT])
                     * prc_pkg::A_W'(prc_pkg::GAIN_Q32);
      prod_b_next[l] = prc_pkg::B_W'(mag0[l][prc_pkg::SPLIT-1:0])
                     * prc_pkg::B_W'(prc_pkg::GAIN_Q32);
      // Truncate the split product at 2^-32, then round off the guard bits
      low_sum[l]  = prc_pkg::LOW_SUM_W'({prod_a1[l][prc_pkg::GAIN_W-prc_pkg::SPLIT-1:0],
                                         prc_pkg::SPLIT'(0)})
                  + prc_pkg::LOW_SUM_W'(prod_b1[l]);
      sum_full[l] = prc_pkg::SUM_W'(prod_a1[l][prc_pkg::A_W-1:prc_pkg::GAIN_W-prc_pkg::SPLIT])
                  + prc_pkg::SUM_W'(low_sum[l][prc_pkg::LOW_SUM_W-1:prc_pkg::GAIN_W]);
      sum_rnd[l]  = (prc_pkg::SUM_W+1)'(sum_full[l])
                  + (prc_pkg::SUM_W+1)'(64'd1 << (prc_pkg::GUARD_BITS - 1));
      rnd_next[l] = sum_rnd[l][prc_pkg::SUM_W:prc_pkg::GUARD_BITS];
      // Restore the sign, add the center and clip to the coordinate range
      off_val[l]  = neg2[l] ? -$signed(prc_pkg::RES_W'(rnd2[l]))
                            : $signed(prc_pkg::RES_W'(rnd2[l]));
      res_full[l] = prc_pkg::RES_W'(ctr2[l]) + off_val[l];
      clip[l]     = 1'b0;
      res_next[l] = prc_pkg::COORD_W'(res_full[l]);
      if (res_full[l] > lim_hi) begin
        clip[l]     = 1'b1;
        res_next[l] = prc_pkg::COORD_W'(lim_hi);
      end else if (res_full[l] < lim_lo) begin
        clip[l]     = 1'b1;
        res_next[l] = prc_pkg::COORD_W'(lim_lo);
      end
    end
  end

  // Advance the payload registers
  always_ff @(posedge clk) begin
    if (rdy[0] && in_valid) begin
      for (int l = 0; l < LANES; l++) begin
        neg0[l] <= vec_in[l][prc_pkg::VEC_W-1];
        mag0[l] <= mag_next[l];
      end
      ctr0[0] <= in_data.cx;
      ctr0[1] <= in_data.cy;
    end
    if (rdy[1] && vld[0]) begin
      for (int l = 0; l < LANES; l++) begin
        neg1[l]    <= neg0[l];
        prod_a1[l] <= prod_a_next[l];
        prod_b1[l] <= prod_b_next[l];
        ctr1[l]    <= ctr0[l];
      end
    end
    if (rdy[2] && vld[1]) begin
      for (int l = 0; l < LANES; l++) begin
        neg2[l] <= neg1[l];
        rnd2[l] <= rnd_next[l];
        ctr2[l] <= ctr1[l];
      end
    end
    if (rdy[3] && vld[2]) begin
      out_data.rx  <= res_next[0];
      out_data.ry  <= res_next[1];
      out_data.sat <= clip[0] | clip[1];
    end
  end

endmodule

### dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench: point rotation about a center, checked against a predictor
// Sends center/end/angle requests through point_in and checks every rotated
// point on point_out against a bit-exact CORDIC predictor kept here (known
// rows: by hand). A short directed table comes first, then random ones with
// random gaps on both sides, one long receiver hold-off and one drain pause.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int     COORD_W         = prc_pkg::COORD_W;
  localparam int     ANGLE_W         = prc_pkg::ANGLE_W;
  localparam int     GUARD_BITS      = prc_pkg::GUARD_BITS;
  localparam int     ROTATION_STAGES = prc_pkg::ROTATION_STAGES;
  localparam int     FULL_TURN       = prc_pkg::FULL_TURN;
  localparam longint COORD_MAX       = prc_pkg::COORD_MAX;
  localparam longint COORD_MIN       = prc_pkg::COORD_MIN;

  typedef prc_pkg::res_t res_t;

  localparam int POINT_COUNT     = 1600;
  localparam int MAX_WAIT        = 7;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int DRAIN_CYCLES    = 40;
  localparam int DRAIN_LIMIT     = 5000;
  localparam int DEG             = prc_pkg::DEG_FRACTION;

  // CORDIC gain 0.60725293500888 as unsigned Q0.32
  localparam logic [63:0] ROT_GAIN_Q32 = 64'd2608131496;

  // Arctangent of 2^-i, 2^32 per full turn
  localparam logic [31:0] ATAN_TURN [32] = '{
    32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2E, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C,
    32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
    32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051,
    32'h00000028, 32'h00000014, 32'h0000000A, 32'h00000005,
    32'h00000002, 32'h00000001, 32'h00000000, 32'h00000000
  };

  localparam logic signed [COORD_W-1:0] CMAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic signed [COORD_W-1:0] CMIN = {1'b1, {(COORD_W-1){1'b0}}};
  localparam logic signed [COORD_W-1:0] C256 = COORD_W'(256);
  localparam logic signed [ANGLE_W-1:0] ANG_MAX = {1'b0, {(ANGLE_W-1){1'b1}}};
  localparam logic signed [ANGLE_W-1:0] ANG_MIN = {1'b1, {(ANGLE_W-1){1'b0}}};

  typedef struct packed {
    logic signed [COORD_W-1:0] center_x;
    logic signed [COORD_W-1:0] center_y;
    logic signed [COORD_W-1:0] end_x;
    logic signed [COORD_W-1:0] end_y;
    logic signed [ANGLE_W-1:0] angle_deg;
  } point_req_t;

  // Directed request; known rows carry a result read off by hand
  typedef struct packed {
    point_req_t req;
    logic       known;
    res_t       want;
  } probe_row_t;

  localparam int PROBE_COUNT = 22;
  localparam probe_row_t PROBES [PROBE_COUNT] = '{
    // coincident points return the center, whatever the angle
    '{'{COORD_W'(0), COORD_W'(0), COORD_W'(0), COORD_W'(0), ANGLE_W'(0)},
      1'b1, '{COORD_W'(0), COORD_W'(0), 1'b0}},
    '{'{CMAX, CMIN, CMAX, CMIN, ANGLE_W'(90 * DEG)}, 1'b1, '{CMAX, CMIN, 1'b0}},
    '{'{CMIN, CMAX, CMIN, CMAX, ANG_MIN}, 1'b1, '{CMIN, CMAX, 1'b0}},
    '{'{COORD_W'(1000), COORD_W'(-2000), COORD_W'(1000), COORD_W'(-2000), ANG_MAX},
      1'b1, '{COORD_W'(1000), COORD_W'(-2000), 1'b0}},
    // half turn across the whole range clips both coordinates
    '{'{CMAX, CMAX, CMIN, CMIN, ANGLE_W'(180 * DEG)}, 1'b1, '{CMAX, CMAX, 1'b1}},
    '{'{CMIN, CMIN, CMAX, CMAX, ANGLE_W'(-180 * DEG)}, 1'b1, '{CMIN, CMIN, 1'b1}},
    // unit-ish vector through the quadrant folds and wrap points
    '{'{COORD_W'(0), COORD_W'(0), C256, COORD_W'(0), ANGLE_W'(90 * DEG)}, 1'b0, '0},
    '{'{COORD_W'(0), COORD_W'(0), C256, COORD_W'(0), ANGLE_W'(-90 * DEG)}, 1'b0, '0},
    '{'{COORD_W'(0), COORD_W'(0), C256, COORD_W'(0), ANGLE_W'(45 * DEG)}, 1'b0, '0},
    '{'{COORD_W'(0), COORD_W'(0), C256, COORD_W'(0), ANGLE_W'(1)}, 1'b0, '0},
    '{'{COORD_W'(0), COORD_W'(0), C256, COORD_W'(0), ANGLE_W'(-1)}, 1'b0, '0},
    '{'{COORD_W'(0), COORD_W'(0), C256, COORD_W'(0), ANGLE_W'(180 * DEG - 1)}, 1'b0, '0},
    '{'{COORD_W'(0), COORD_W'(0), C256, COORD_W'(0), ANGLE_W'(360 * DEG)}, 1'b0, '0},
    '{'{COORD_W'(0), COORD_W'(0), C256, COORD_W'(0), ANGLE_W'(-360 * DEG)}, 1'b0, '0},
    '{'{COORD_W'(0), COORD_W'(0), C256, COORD_W'(0), ANGLE_W'(90 * DEG - 1)}, 1'b0, '0},
    '{'{COORD_W'(0), COORD_W'(0), C256, COORD_W'(0), ANGLE_W'(90 * DEG + 1)}, 1'b0, '0},
    '{'{COORD_W'(0), COORD_W'(0), C256, COORD_W'(0), ANGLE_W'(270 * DEG)}, 1'b0, '0},
    '{'{COORD_W'(0), COORD_W'(0), C256, COORD_W'(0), ANGLE_W'(270 * DEG + 1)}, 1'b0, '0},
    // full-span vectors and an off-origin center
    '{'{CMIN, CMIN, CMAX, CMAX, ANGLE_W'(0)}, 1'b0, '0},
    '{'{COORD_W'(0), COORD_W'(0), CMIN, CMAX, ANGLE_W'(270 * DEG)}, 1'b0, '0},
    '{'{COORD_W'(1000), COORD_W'(-2000), COORD_W'(-5000), COORD_W'(3000),
        ANGLE_W'(30 * DEG)}, 1'b0, '0},
    '{'{CMAX, COORD_W'(0), CMAX, C256, ANGLE_W'(90 * DEG)}, 1'b0, '0}
  };

  logic clk = 1'b0;
  logic rst;

  prc_in_if  point_in ();
  prc_out_if point_out ();

  point_rotate_about_center_top uut (
    .clk       (clk),
    .rst       (rst),
    .point_in  (point_in),
    .point_out (point_out)
  );

  res_t offered_points [$];   // presented on point_in, not yet accepted
  res_t rotated_points [$];   // accepted, result still due
  int   mismatches = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #400_000;
    $display("point_rotate_about_center_top: mismatch");
    $finish;
  end

  // Apply the gain with the guard bits rounded off, half away from zero
  function automatic longint apply_cordic_gain(input longint v);
    logic [63:0] m, hi, lo, a, b, s;
    m  = (v < 0) ? 64'(-v) : 64'(v);
    hi = m >> 26;
    lo = m & ((64'd1 << 26) - 64'd1);
    a  = hi * ROT_GAIN_Q32;
    b  = lo * ROT_GAIN_Q32;
    s  = (a >> 6) + ((((a & 64'd63) << 26) + b) >> 32);
    s  = (s + (64'd1 << (GUARD_BITS - 1))) >> GUARD_BITS;
    return (v < 0) ? -longint'(s) : longint'(s);
  endfunction

  // Rotate end about center by angle_deg, recenter and clip
  function automatic res_t rotate_point(input point_req_t req);
    longint      cx, cy, ang, x, y, z, xs, ys, rx, ry;
    logic [63:0] mag;
    logic [31:0] turn;
    int          stage;
    logic        clipped;
    res_t        r;
    cx   = longint'(req.center_x);
    cy   = longint'(req.center_y);
    ang  = longint'(req.angle_deg);
    mag  = (ang < 0) ? 64'(-ang) : 64'(ang);
    turn = 32'(((mag << 32) + 64'(FULL_TURN / 2)) / 64'(FULL_TURN));
    if (ang < 0) begin
      turn = 32'd0 - turn;
    end
    x = (longint'(req.end_x) - cx) * (64'sd1 <<< GUARD_BITS);
    y = (longint'(req.end_y) - cy) * (64'sd1 <<< GUARD_BITS);
    // fold the second and third quadrants by a half turn
    if (turn[31:30] == 2'b01 || turn[31:30] == 2'b10) begin
      x    = -x;
      y    = -y;
      turn = turn + 32'h8000_0000;
    end
    z = longint'($signed(turn));
    for (stage = 0; stage < ROTATION_STAGES; stage++) begin
      xs = x >>> (stage % 32);
      ys = y >>> (stage % 32);
      if (z >= 0) begin
        x = x - ys;
        y = y + xs;
        z = z - longint'(ATAN_TURN[stage % 32]);
      end else begin
        x = x + ys;
        y = y - xs;
        z = z + longint'(ATAN_TURN[stage % 32]);
      end
    end
    rx = cx + apply_cordic_gain(x);
    ry = cy + apply_cordic_gain(y);
    clipped = 1'b0;
    if (rx > COORD_MAX) begin rx = COORD_MAX; clipped = 1'b1; end
    if (rx < COORD_MIN) begin rx = COORD_MIN; clipped = 1'b1; end
    if (ry > COORD_MAX) begin ry = COORD_MAX; clipped = 1'b1; end
    if (ry < COORD_MIN) begin ry = COORD_MIN; clipped = 1'b1; end
    r.rx  = rx[COORD_W-1:0];
    r.ry  = ry[COORD_W-1:0];
    r.sat = clipped;
    return r;
  endfunction

  // Mostly small coordinates, some extremes, some anywhere in range
  function automatic logic signed [COORD_W-1:0] pick_coord();
    case ($urandom_range(0, 7))
      0: return COORD_W'($urandom);
      1: begin
        case ($urandom_range(0, 3))
          0:       return CMAX;
          1:       return CMIN;
          2:       return '0;
          default: return '1;
        endcase
      end
      default: return COORD_W'(int'($urandom_range(0, 65535)) - 32768);
    endcase
  endfunction

  function automatic point_req_t pick_point();
    point_req_t req;
    req.center_x = pick_coord();
    req.center_y = pick_coord();
    case ($urandom_range(0, 9))
      0: begin
        req.end_x = req.center_x;
        req.end_y = req.center_y;
      end
      1, 2: begin
        req.end_x = pick_coord();
        req.end_y = pick_coord();
      end
      default: begin
        req.end_x = COORD_W'(int'(req.center_x) + int'($urandom_range(0, 8191)) - 4096);
        req.end_y = COORD_W'(int'(req.center_y) + int'($urandom_range(0, 8191)) - 4096);
      end
    endcase
    case ($urandom_range(0, 5))
      0: req.angle_deg = ANGLE_W'($urandom);
      // land on or next to a quadrant boundary
      1: req.angle_deg = ANGLE_W'((int'($urandom_range(0, 8)) - 4) * 90 * DEG
                                  + int'($urandom_range(0, 2)) - 1);
      default: req.angle_deg = ANGLE_W'(int'($urandom_range(0, 720 * DEG)) - 360 * DEG);
    endcase
    return req;
  endfunction

  // Present one request after an idle gap and hold it until accepted
  task automatic offer_point(input point_req_t req, input res_t want, input int idle);
    offered_points.push_back(want);
    if (idle > 0) begin
      point_in.valid <= 1'b0;
      repeat (idle) @(posedge clk);
    end
    point_in.valid     <= 1'b1;
    point_in.center_x  <= req.center_x;
    point_in.center_y  <= req.center_y;
    point_in.end_x     <= req.end_x;
    point_in.end_y     <= req.end_y;
    point_in.angle_deg <= req.angle_deg;
    do @(posedge clk); while (!point_in.ready);
  endtask

  // Check each result, then move the accepted request's expectation along
  always @(posedge clk) begin : check_rotation
    res_t want;
    if (!rst) begin
      if (point_out.valid && point_out.ready) begin
        if (rotated_points.size() == 0) begin
          $error("rotated point with no request outstanding: x %0d y %0d",
                 point_out.rotated_x, point_out.rotated_y);
          mismatches++;
        end else begin
          want = rotated_points.pop_front();
          if (point_out.rotated_x !== want.rx) begin
            $error("rotated_x: expected %0d, got %0d", want.rx, point_out.rotated_x);
            mismatches++;
          end
          if (point_out.rotated_y !== want.ry) begin
            $error("rotated_y: expected %0d, got %0d", want.ry, point_out.rotated_y);
            mismatches++;
          end
          if (point_out.saturated !== want.sat) begin
            $error("saturated: expected %0d, got %0d", want.sat, point_out.saturated);
            mismatches++;
          end
        end
      end
      if (point_in.valid && point_in.ready) begin
        rotated_points.push_back(offered_points.pop_front());
      end
    end
  end

  // Receiver: random stalls, gap-free stretches and one long hold-off
  initial begin : drain_results
    int   stall;
    int   taken;
    logic held;
    point_out.ready = 1'b0;
    taken = 0;
    held  = 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (taken == 400 && !held) begin
        held = 1'b1;
        point_out.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end
      stall = ((taken / 200) % 3 == 1) ? 0 : $urandom_range(0, MAX_WAIT);
      if (stall > 0) begin
        point_out.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      point_out.ready <= 1'b1;
      do @(posedge clk); while (!point_out.valid);
      taken++;
    end
  end

  // Sender: directed table, then random requests, then drain and report
  initial begin : send_requests
    point_req_t req;
    int         idle;
    int         n;
    int         waited;
    rst                = 1'b1;
    point_in.valid     = 1'b0;
    point_in.center_x  = '0;
    point_in.center_y  = '0;
    point_in.end_x     = '0;
    point_in.end_y     = '0;
    point_in.angle_deg = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    for (n = 0; n < PROBE_COUNT; n++) begin
      offer_point(PROBES[n].req,
                  PROBES[n].known ? PROBES[n].want : rotate_point(PROBES[n].req),
                  $urandom_range(0, MAX_WAIT));
    end

    for (n = 0; n < POINT_COUNT; n++) begin
      // pause once until every outstanding result has come back
      if (n == POINT_COUNT / 2) begin
        point_in.valid <= 1'b0;
        do @(posedge clk); while (offered_points.size() != 0 || rotated_points.size() != 0);
      end
      req  = pick_point();
      idle = ((n / 150) % 3 == 2) ? 0 : $urandom_range(0, MAX_WAIT);
      offer_point(req, rotate_point(req), idle);
    end
    point_in.valid <= 1'b0;

    waited = 0;
    do begin
      @(posedge clk);
      waited++;
    end while ((offered_points.size() != 0 || rotated_points.size() != 0)
               && waited < DRAIN_LIMIT);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (rotated_points.size() != 0) begin
      $error("%0d rotated points never came out", rotated_points.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("point_rotate_about_center_top: match");
    end else begin
      $display("point_rotate_about_center_top: mismatch");
    end
    $finish;
  end

endmodule
